@@ hdl/incscan_pkg.sv @@
`default_nettype none

package incscan_pkg;

    // width of every result field
    localparam int OUT_W          = 20;
    // five result fields packed and padded to whole bytes
    localparam int OUT_DATA_W     = 104;
    localparam int OFFSET_BITS_DEF = 20;
    localparam int KEYWORD_LEN    = 7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_HASH    = 4'd1,
        PH_KEYWORD = 4'd2,
        PH_NEED_WS = 4'd3,
        PH_NAME_WS = 4'd4,
        PH_NAME    = 4'd5,
        PH_CLOSED  = 4'd6,
        PH_SKIP    = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_CR   = 2'd1,
        TERM_LF   = 2'd2
    } t_term;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] kw_idx;
        t_term      term;
    } t_scan_ctl;

    // characters of the keyword "include"
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h69;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h75;
            3'd5:    ch = 8'h64;
            3'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB);
    endfunction

endpackage

`default_nettype wire

@@ hdl/incscan_step.sv @@
`default_nettype none

module incscan_step #(
    parameter int OFFSET_BITS = incscan_pkg::OFFSET_BITS_DEF
) (
    input  wire  incscan_pkg::t_scan_ctl    i_ctl,
    input  wire  logic [OFFSET_BITS-1:0]    i_pos,
    input  wire  logic [OFFSET_BITS-1:0]    i_lso,
    input  wire  logic [OFFSET_BITS-1:0]    i_line,
    input  wire  logic [OFFSET_BITS-1:0]    i_qs,
    input  wire  logic [OFFSET_BITS-1:0]    i_ql,
    input  wire  logic [7:0]                i_byte,
    input  wire  logic                      i_last,
    output incscan_pkg::t_scan_ctl          o_ctl,
    output logic [OFFSET_BITS-1:0]          o_pos,
    output logic [OFFSET_BITS-1:0]          o_lso,
    output logic [OFFSET_BITS-1:0]          o_line,
    output logic [OFFSET_BITS-1:0]          o_qs,
    output logic [OFFSET_BITS-1:0]          o_ql,
    output logic                            o_emit,
    output logic [incscan_pkg::OUT_W-1:0]   o_line_offset,
    output logic [incscan_pkg::OUT_W-1:0]   o_line_end,
    output logic [incscan_pkg::OUT_W-1:0]   o_name_offset,
    output logic [incscan_pkg::OUT_W-1:0]   o_name_length,
    output logic [incscan_pkg::OUT_W-1:0]   o_following_line
);

    localparam logic [OFFSET_BITS-1:0] MAX_CNT = {OFFSET_BITS{1'b1}};

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == MAX_CNT) ? v : v + 1'b1;
    endfunction

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] end_val;
    logic [2:0]             kw_next;
    logic                   is_term;
    logic                   pair;
    logic [7:0]             mate;

    assign pos_inc = sat_inc(i_pos);
    assign kw_next = i_ctl.kw_idx + 3'd1;
    assign is_term = (i_byte == incscan_pkg::CH_CR) || (i_byte == incscan_pkg::CH_LF);
    assign mate    = (i_ctl.term == incscan_pkg::TERM_CR) ? incscan_pkg::CH_LF
                                                          : incscan_pkg::CH_CR;
    assign pair    = (i_ctl.term != incscan_pkg::TERM_NONE) && (i_byte == mate);

    always_comb begin
        o_ctl      = i_ctl;
        o_ctl.term = incscan_pkg::TERM_NONE;
        o_pos      = pos_inc;
        o_lso      = i_lso;
        o_line     = i_line;
        o_qs       = i_qs;
        o_ql       = i_ql;
        o_emit     = 1'b0;
        end_val    = i_pos;

        if (pair) begin
            // second byte of a two-byte line end
            o_lso = pos_inc;
        end else if (is_term) begin
            o_emit       = (i_ctl.phase == incscan_pkg::PH_CLOSED);
            o_ctl.term   = (i_byte == incscan_pkg::CH_CR) ? incscan_pkg::TERM_CR
                                                          : incscan_pkg::TERM_LF;
            o_line       = sat_inc(i_line);
            o_lso        = pos_inc;
            o_ctl.phase  = incscan_pkg::PH_LEAD;
            o_ctl.kw_idx = 3'd0;
        end else begin
            case (i_ctl.phase)
                incscan_pkg::PH_LEAD: begin
                    if (i_byte == incscan_pkg::CH_HASH) begin
                        o_ctl.phase = incscan_pkg::PH_HASH;
                    end else if (!incscan_pkg::is_blank(i_byte)) begin
                        o_ctl.phase = incscan_pkg::PH_SKIP;
                    end
                end
                incscan_pkg::PH_HASH: begin
                    if (i_byte == incscan_pkg::keyword_char(3'd0)) begin
                        o_ctl.phase  = incscan_pkg::PH_KEYWORD;
                        o_ctl.kw_idx = 3'd1;
                    end else if (!incscan_pkg::is_blank(i_byte)) begin
                        o_ctl.phase = incscan_pkg::PH_SKIP;
                    end
                end
                incscan_pkg::PH_KEYWORD: begin
                    if (i_byte == incscan_pkg::keyword_char(i_ctl.kw_idx)) begin
                        o_ctl.kw_idx = kw_next;
                        if (kw_next == 3'(incscan_pkg::KEYWORD_LEN)) begin
                            o_ctl.phase = incscan_pkg::PH_NEED_WS;
                        end
                    end else begin
                        o_ctl.phase = incscan_pkg::PH_SKIP;
                    end
                end
                incscan_pkg::PH_NEED_WS: begin
                    o_ctl.phase = incscan_pkg::is_blank(i_byte) ? incscan_pkg::PH_NAME_WS
                                                                : incscan_pkg::PH_SKIP;
                end
                incscan_pkg::PH_NAME_WS: begin
                    if (i_byte == incscan_pkg::CH_QUOTE) begin
                        o_ctl.phase = incscan_pkg::PH_NAME;
                        o_qs        = pos_inc;
                        o_ql        = '0;
                    end else if (!incscan_pkg::is_blank(i_byte)) begin
                        o_ctl.phase = incscan_pkg::PH_SKIP;
                    end
                end
                incscan_pkg::PH_NAME: begin
                    if (i_byte == incscan_pkg::CH_QUOTE) begin
                        o_ctl.phase = incscan_pkg::PH_CLOSED;
                    end else begin
                        o_ql = sat_inc(i_ql);
                    end
                end
                default: begin
                end
            endcase
            // text ends on a directive line: end is the text length
            if (i_last && (o_ctl.phase == incscan_pkg::PH_CLOSED)) begin
                o_emit  = 1'b1;
                end_val = pos_inc;
            end
        end

        if (i_last) begin
            o_ctl.phase  = incscan_pkg::PH_LEAD;
            o_ctl.kw_idx = 3'd0;
            o_ctl.term   = incscan_pkg::TERM_NONE;
            o_pos        = '0;
            o_lso        = '0;
            o_line       = OFFSET_BITS'(1);
            o_qs         = '0;
            o_ql         = '0;
        end
    end

    assign o_line_offset    = incscan_pkg::OUT_W'(i_lso);
    assign o_line_end       = incscan_pkg::OUT_W'(end_val);
    assign o_name_offset    = incscan_pkg::OUT_W'(i_qs);
    assign o_name_length    = incscan_pkg::OUT_W'(i_ql);
    assign o_following_line = incscan_pkg::OUT_W'(sat_inc(i_line));

endmodule

`default_nettype wire

@@ hdl/include_directive_scanner_core.sv @@
// a byte is held in the byte register, and its result in the result register, which drives m_axis
// throughput: one byte per cycle, sustained while m_axis_tready stays high
// the scan itself is one pass of logic between the byte register and the result register
// reset (i_rst_n low, synchronous): both pipeline registers empty, scanner at line start,
// position zero, line number one
`default_nettype none

module include_directive_scanner_core #(
    parameter int OFFSET_BITS = incscan_pkg::OFFSET_BITS_DEF
) (
    input  wire  logic                              i_clk,
    input  wire  logic                              i_rst_n,
    input  wire  logic                              s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
    input  wire  logic                              s_axis_tlast,  // final_byte
    output logic                                    m_axis_tvalid,
    input  wire  logic                              m_axis_tready,
    // [19:0] line_offset, [39:20] line_end, [59:40] name_offset,
    // [79:60] name_length, [99:80] following_line, [103:100] zero
    output logic [incscan_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int OW = incscan_pkg::OUT_W;

    // input byte register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // scanner state
    incscan_pkg::t_scan_ctl r_ctl;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_lso;
    logic [OFFSET_BITS-1:0] r_line;
    logic [OFFSET_BITS-1:0] r_qs;
    logic [OFFSET_BITS-1:0] r_ql;

    incscan_pkg::t_scan_ctl n_ctl;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] n_lso;
    logic [OFFSET_BITS-1:0] n_line;
    logic [OFFSET_BITS-1:0] n_qs;
    logic [OFFSET_BITS-1:0] n_ql;

    // result register
    logic          r_out_valid;
    logic [OW-1:0] r_line_offset;
    logic [OW-1:0] r_line_end;
    logic [OW-1:0] r_name_offset;
    logic [OW-1:0] r_name_length;
    logic [OW-1:0] r_following_line;

    logic          n_emit;
    logic [OW-1:0] n_line_offset;
    logic [OW-1:0] n_line_end;
    logic [OW-1:0] n_name_offset;
    logic [OW-1:0] n_name_length;
    logic [OW-1:0] n_following_line;

    logic step_en;

    // the held byte moves on once the result register is free or being drained,
    // whether or not it produces a result
    assign step_en       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step_en;

    incscan_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_ctl            (r_ctl),
        .i_pos            (r_pos),
        .i_lso            (r_lso),
        .i_line           (r_line),
        .i_qs             (r_qs),
        .i_ql             (r_ql),
        .i_byte           (r_in_byte),
        .i_last           (r_in_last),
        .o_ctl            (n_ctl),
        .o_pos            (n_pos),
        .o_lso            (n_lso),
        .o_line           (n_line),
        .o_qs             (n_qs),
        .o_ql             (n_ql),
        .o_emit           (n_emit),
        .o_line_offset    (n_line_offset),
        .o_line_end       (n_line_end),
        .o_name_offset    (n_name_offset),
        .o_name_length    (n_name_length),
        .o_following_line (n_following_line)
    );

    // control and scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl.phase  <= incscan_pkg::PH_LEAD;
            r_ctl.kw_idx <= 3'd0;
            r_ctl.term   <= incscan_pkg::TERM_NONE;
            r_pos       <= '0;
            r_lso       <= '0;
            r_line      <= OFFSET_BITS'(1);
            r_qs        <= '0;
            r_ql        <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step_en) begin
                r_out_valid <= n_emit;
                r_ctl       <= n_ctl;
                r_pos       <= n_pos;
                r_lso       <= n_lso;
                r_line      <= n_line;
                r_qs        <= n_qs;
                r_ql        <= n_ql;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (step_en && n_emit) begin
            r_line_offset    <= n_line_offset;
            r_line_end       <= n_line_end;
            r_name_offset    <= n_name_offset;
            r_name_length    <= n_name_length;
            r_following_line <= n_following_line;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_following_line, r_name_length, r_name_offset,
                            r_line_end, r_line_offset};

endmodule

`default_nettype wire

@@ verif/include_scan_checker.sv @@
`timescale 1ns / 1ps

module include_scan_checker
    import incscan_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] text_byte
    input  wire logic                  i_s_tlast,   // final_byte
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [19:0] line_offset, [39:20] line_end, [59:40] name_offset,
    // [79:60] name_length, [99:80] following_line, [103:100] zero
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                         o_fail_count,
    output int                         o_awaiting
);

    localparam logic [8*KEYWORD_LEN-1:0] KEYWORD_TEXT = "include";

    // highest field first, same layout as the result bus
    typedef struct packed {
        logic [OUT_W-1:0] following_line;
        logic [OUT_W-1:0] name_length;
        logic [OUT_W-1:0] name_offset;
        logic [OUT_W-1:0] line_end;
        logic [OUT_W-1:0] line_offset;
    } t_directive;

    t_directive       pending_directives[$];
    int               fail_count = 0;

    // scanner state
    t_phase           phase;
    logic [2:0]       kw_idx;
    t_term            pend;
    logic [OUT_W-1:0] byte_pos;
    logic [OUT_W-1:0] line_start;
    logic [OUT_W-1:0] line_no;
    logic [OUT_W-1:0] quote_at;
    logic [OUT_W-1:0] quote_len;

    function automatic logic [OUT_W-1:0] sat_next(input logic [OUT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    task automatic rewind_scanner();
        phase      = PH_LEAD;
        kw_idx     = '0;
        pend       = TERM_NONE;
        byte_pos   = '0;
        line_start = '0;
        line_no    = OUT_W'(1);
        quote_at   = '0;
        quote_len  = '0;
    endtask

    task automatic push_directive(input logic [OUT_W-1:0] end_at);
        t_directive d;
        d.line_offset    = line_start;
        d.line_end       = end_at;
        d.name_offset    = quote_at;
        d.name_length    = quote_len;
        d.following_line = sat_next(line_no);
        pending_directives.push_back(d);
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic last);
        logic [OUT_W-1:0] here;
        logic [7:0]       mate;
        logic             paired;
        here   = byte_pos;
        paired = 1'b0;
        // second half of a cr lf or lf cr pair
        if (pend != TERM_NONE) begin
            mate = (pend == TERM_CR) ? CH_LF : CH_CR;
            pend = TERM_NONE;
            if (c == mate) begin
                line_start = sat_next(here);
                byte_pos   = sat_next(here);
                paired     = 1'b1;
            end
        end
        if (!paired) begin
            if (c == CH_CR || c == CH_LF) begin
                if (phase == PH_CLOSED) begin
                    push_directive(here);
                end
                pend       = (c == CH_CR) ? TERM_CR : TERM_LF;
                line_no    = sat_next(line_no);
                line_start = sat_next(here);
                phase      = PH_LEAD;
                kw_idx     = '0;
            end else begin
                case (phase)
                    PH_LEAD: begin
                        if (c == CH_HASH) phase = PH_HASH;
                        else if (!blank_char(c)) phase = PH_SKIP;
                    end
                    PH_HASH: begin
                        if (c == KEYWORD_TEXT[8*(KEYWORD_LEN-1) +: 8]) begin
                            phase  = PH_KEYWORD;
                            kw_idx = 3'd1;
                        end else if (!blank_char(c)) begin
                            phase = PH_SKIP;
                        end
                    end
                    PH_KEYWORD: begin
                        if (kw_idx < KEYWORD_LEN &&
                            c == KEYWORD_TEXT[8*(KEYWORD_LEN-1-kw_idx) +: 8]) begin
                            kw_idx = kw_idx + 1'b1;
                            if (kw_idx == KEYWORD_LEN) phase = PH_NEED_WS;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                    PH_NEED_WS: phase = blank_char(c) ? PH_NAME_WS : PH_SKIP;
                    PH_NAME_WS: begin
                        if (c == CH_QUOTE) begin
                            phase     = PH_NAME;
                            quote_at  = sat_next(here);
                            quote_len = '0;
                        end else if (!blank_char(c)) begin
                            phase = PH_SKIP;
                        end
                    end
                    PH_NAME: begin
                        if (c == CH_QUOTE) phase = PH_CLOSED;
                        else quote_len = sat_next(quote_len);
                    end
                    default: ;
                endcase
                // text ends on the directive line
                if (last && phase == PH_CLOSED) begin
                    push_directive(sat_next(here));
                end
            end
            byte_pos = sat_next(here);
        end
        if (last) begin
            rewind_scanner();
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial rewind_scanner();

    always @(posedge i_clk) begin
        t_directive want;
        if (!i_rst_n) begin
            rewind_scanner();
            pending_directives.delete();
        end else begin
            // results trail their byte through the byte and result registers, so compare before predicting
            if (i_m_tvalid && i_m_tready) begin
                if (pending_directives.size() == 0) begin
                    $error("unexpected result transfer: %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = pending_directives.pop_front();
                    check_field("line_offset", want.line_offset, i_m_tdata[0*OUT_W +: OUT_W]);
                    check_field("line_end", want.line_end, i_m_tdata[1*OUT_W +: OUT_W]);
                    check_field("name_offset", want.name_offset, i_m_tdata[2*OUT_W +: OUT_W]);
                    check_field("name_length", want.name_length, i_m_tdata[3*OUT_W +: OUT_W]);
                    check_field("following_line", want.following_line,
                                i_m_tdata[4*OUT_W +: OUT_W]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                scan_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_fail_count <= fail_count;
        o_awaiting   <= pending_directives.size();
    end

endmodule

@@ verif/tb_include_directive_scanner_core.sv @@
`timescale 1ns / 1ps

module tb_include_directive_scanner_core;
    import incscan_pkg::*;

    // cycles without any transfer on either side before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // random text volume, in bytes
    localparam int RANDOM_BYTES = 900;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] text_byte
    logic                  s_axis_tlast = 1'b0; // final_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [19:0] line_offset, [39:20] line_end, [59:40] name_offset,
    // [79:60] name_length, [99:80] following_line, [103:100] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int                    fail_count;
    int                    awaiting;
    int                    idle_cycles = 0;
    int                    sink_stall = 0;
    // while set, neither side inserts gaps
    bit                    calm = 1'b0;
    // bytes of the text being assembled
    logic [7:0]            text_buf[$];

    include_directive_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    include_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_awaiting   (awaiting)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // idle length: mostly none, sometimes short, rarely a long stretch
    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (calm || r < 70) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(1, 0) ? CH_SPACE : CH_TAB;
    endfunction

    // any byte but a line terminator, leaning toward characters the scanner cares about
    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        string      hot;
        hot = "#\" \tinclude";
        if ($urandom_range(1, 0)) c = hot[$urandom_range(hot.len() - 1, 0)];
        else c = 8'($urandom_range(255, 0));
        while (c == CH_CR || c == CH_LF) c = 8'($urandom_range(255, 0));
        return c;
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = stray_char();
        while (c == CH_QUOTE) c = stray_char();
        return c;
    endfunction

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // single terminators and all the pairings, joined or not
    task automatic add_line_end();
        case ($urandom_range(5, 0))
            0: text_buf.push_back(CH_LF);
            1: text_buf.push_back(CH_CR);
            2: begin
                text_buf.push_back(CH_CR);
                text_buf.push_back(CH_LF);
            end
            3: begin
                text_buf.push_back(CH_LF);
                text_buf.push_back(CH_CR);
            end
            4: begin
                text_buf.push_back(CH_CR);
                text_buf.push_back(CH_CR);
            end
            default: begin
                text_buf.push_back(CH_LF);
                text_buf.push_back(CH_LF);
            end
        endcase
    endtask

    // well-formed directive with random spacing, name and tail; when broken it is
    // cut short (unclosed name, missing separator) or has one byte replaced
    task automatic add_directive(input bit broken);
        logic [7:0] ln[$];
        string      kw;
        int         i;
        int         n;
        int         k;
        kw = "include";
        repeat ($urandom_range(2, 0)) ln.push_back(blank_char());
        ln.push_back(CH_HASH);
        repeat ($urandom_range(2, 0)) ln.push_back(blank_char());
        for (i = 0; i < kw.len(); i++) ln.push_back(kw[i]);
        repeat ($urandom_range(2, 1)) ln.push_back(blank_char());
        ln.push_back(CH_QUOTE);
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 0);
        repeat (n) ln.push_back(name_char());
        ln.push_back(CH_QUOTE);
        // trailing text after the closing quote is ignored by the block
        if ($urandom_range(1, 0)) begin
            repeat ($urandom_range(4, 1)) ln.push_back(stray_char());
        end
        if (broken) begin
            k = $urandom_range(ln.size() - 1, 0);
            if ($urandom_range(1, 0)) begin
                while (ln.size() > k) void'(ln.pop_back());
            end else begin
                ln[k] = stray_char();
            end
        end
        foreach (ln[j]) text_buf.push_back(ln[j]);
    endtask

    // one byte transfer, with an optional gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sends the assembled text, flagging its last byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // result side: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            sink_stall    <= gap_len();
        end
    end

    // watchdog: any transfer restarts the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int lines;
        int li;
        int pick;

        // synchronous reset, released on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty name, result on the final byte of the text
        add_str("#include \"\"");
        send_text();

        // blanks everywhere, extreme bytes in the name, trailing text, cr lf pair
        add_str(" \t#\tinclude \"");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        add_str("\"x");
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_LF);
        // keyword directly followed by a terminator, then an lf cr pair
        add_str("#include");
        text_buf.push_back(CH_LF);
        text_buf.push_back(CH_CR);
        // name left open by a cr, then a second cr as its own line end
        add_str("#include \"ab");
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_CR);
        // text ends on a lone lf that must not pair with the next text
        add_str("#include \"q\"");
        text_buf.push_back(CH_LF);
        send_text();
        text_buf.push_back(CH_CR);
        add_str("#include \"z\"");
        send_text();

        // random texts, mostly directives with random content
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            calm  = ($urandom_range(3, 0) == 0);
            lines = $urandom_range(6, 1);
            for (li = 0; li < lines; li++) begin
                pick = $urandom_range(9, 0);
                if (pick < 5) begin
                    add_directive(1'b0);
                end else if (pick < 7) begin
                    add_directive(1'b1);
                end else if (pick < 9) begin
                    repeat ($urandom_range(10, 1)) text_buf.push_back(stray_char());
                end
                // the last line is left unterminated half the time
                if (li < lines - 1 || $urandom_range(1, 0)) add_line_end();
            end
            if (text_buf.size() == 0) text_buf.push_back(stray_char());
            sent += text_buf.size();
            send_text();
        end
        calm = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain, then keep the clock running to show any stray result
        while (awaiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && awaiting == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ include_directive_scanner_core.f @@
hdl/incscan_pkg.sv
hdl/incscan_step.sv
hdl/include_directive_scanner_core.sv
verif/include_scan_checker.sv
verif/tb_include_directive_scanner_core.sv
